// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the RTL; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only while out of reset
`define ASSERT_CLKD(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLKD(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== src/cpm_pkg.sv =====
// ----------------------------------------------------------------------------
// cpm_pkg
// Types, codes and helpers for the capture period monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpm_pkg;

    localparam int CHANNELS = 2;
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int OP_W     = 2;
    localparam int CH_W     = 1;
    localparam int VAL_W    = 16;
    localparam int ST_W     = 2;
    localparam int PERIOD_W = 18;
    localparam int CFG_IDX_W = 2;

    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_CAPTURE = 2'd1;
    localparam logic [OP_W-1:0] OP_START   = 2'd2;
    localparam logic [OP_W-1:0] OP_STOP    = 2'd3;

    localparam logic [ST_W-1:0] ST_ERROR   = 2'd0;
    localparam logic [ST_W-1:0] ST_KNOWN   = 2'd1;
    localparam logic [ST_W-1:0] ST_UNKNOWN = 2'd2;
    localparam logic [ST_W-1:0] ST_WAIT    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_TIMEOUT = 2'd1;

    localparam logic [VAL_W-1:0] TIMEOUT_RESET = 16'd200;

    // us = ticks * 256 / 100 = (ticks * 64) / 25, divide by 25 via reciprocal
    localparam int SCALED_W    = VAL_W + 6;
    localparam int RECIP_SHIFT = 27;
    localparam int RECIP_W     = 23;
    localparam int PROD_W      = SCALED_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_25 = 23'd5368710;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [CH_W-1:0]  channel;
        logic [VAL_W-1:0] capture_value;
        logic [VAL_W-1:0] elapsed_ms;
    } item_t;

    typedef struct packed {
        logic [ST_W-1:0]     channel_status;
        logic [PERIOD_W-1:0] period_us;
        logic                period_ready;
    } result_t;

    typedef struct packed {
        logic             capture_mode;
        logic [VAL_W-1:0] edge_timeout;
    } cfg_t;

    function automatic logic [PERIOD_W-1:0] ticks_to_us(input logic [VAL_W-1:0] ticks);
        logic [SCALED_W-1:0] scaled;
        logic [PROD_W-1:0]   prod;
        scaled = {ticks, 6'b0};
        prod   = PROD_W'(scaled) * PROD_W'(RECIP_25);
        return prod[RECIP_SHIFT +: PERIOD_W];
    endfunction

endpackage

// ===== src/cpm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// cpm_cfg_regs
// Configuration register file: capture mode and timeout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpm_cfg_regs
    import cpm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CAPTURE_MODE: cfg_next.capture_mode = cfg_data[0];
                CFG_EDGE_TIMEOUT: cfg_next.edge_timeout = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.capture_mode <= 1'b1;
            cfg_reg.edge_timeout <= TIMEOUT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/cpm_chan_core.sv =====
// ----------------------------------------------------------------------------
// cpm_chan_core
// Per-channel state records, their update for one item and the status read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpm_chan_core
    import cpm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic [ST_W-1:0]  state_reg  [CHANNELS];
    logic [ST_W-1:0]  state_next [CHANNELS];
    logic [VAL_W-1:0] last_reg   [CHANNELS];
    logic [VAL_W-1:0] last_next  [CHANNELS];
    logic [VAL_W-1:0] tl_reg     [CHANNELS];
    logic [VAL_W-1:0] tl_next    [CHANNELS];
    logic [VAL_W-1:0] period_reg [CHANNELS];
    logic [VAL_W-1:0] period_next[CHANNELS];

    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic [ST_W-1:0]  sel_state;
    logic             known;

    assign in_range = (int'(item.channel) < CHANNELS);
    assign idx      = IDX_W'(item.channel);

    always_comb
    begin
        state_next  = state_reg;
        last_next   = last_reg;
        tl_next     = tl_reg;
        period_next = period_reg;
        case (item.opcode)
            OP_TICK:
            begin
                if (cfg.capture_mode)
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        if (tl_reg[i] != '0)
                        begin
                            if (item.elapsed_ms < tl_reg[i])
                            begin
                                tl_next[i] = tl_reg[i] - item.elapsed_ms;
                            end
                            else
                            begin
                                state_next[i] = ST_ERROR;
                                tl_next[i]    = '0;
                            end
                        end
                    end
                end
            end
            OP_CAPTURE:
            begin
                if (cfg.capture_mode && in_range)
                begin
                    if ((state_reg[idx] == ST_ERROR) || (state_reg[idx] == ST_UNKNOWN))
                    begin
                        state_next[idx] = ST_WAIT;
                    end
                    else
                    begin
                        period_next[idx] = item.capture_value - last_reg[idx];
                        state_next[idx]  = ST_KNOWN;
                    end
                    last_next[idx] = item.capture_value;
                    tl_next[idx]   = cfg.edge_timeout;
                end
            end
            OP_START:
            begin
                if (cfg.capture_mode)
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        state_next[i] = ST_UNKNOWN;
                        tl_next[i]    = cfg.edge_timeout;
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    state_next[i] = ST_UNKNOWN;
                    tl_next[i]    = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                state_reg[i] <= ST_UNKNOWN;
                last_reg[i]  <= '0;
                tl_reg[i]    <= '0;
            end
        end
        else if (fire)
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            tl_reg    <= tl_next;
        end
    end

    // period is only read in the known state, which follows a write
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            period_reg <= period_next;
        end
    end

    assign sel_state = in_range ? state_next[idx] : ST_ERROR;
    assign known     = in_range && (sel_state == ST_KNOWN);

    always_comb
    begin
        result.channel_status = sel_state;
        result.period_ready   = known;
        result.period_us      = known ? ticks_to_us(period_next[idx]) : '0;
    end

endmodule

// ===== src/capture_period_monitor_unit.sv =====
// ----------------------------------------------------------------------------
// capture_period_monitor_unit
// Path: the input item is registered, its status is computed from it and registered in the output stage.
// Throughput: one item per cycle; a stalled output holds the input stage.
// Reset: channels unknown, timeouts disarmed, capture mode on, timeout 200 ms, stages empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module capture_period_monitor_unit
    import cpm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // capture_value, elapsed_ms
    input  logic [2:0]           s_tuser,   // opcode, channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // period_us, zero fill
    output logic [2:0]           m_tuser,   // channel_status, period_ready
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_vld_reg;
    logic    in_vld_next;
    result_t core_result;
    result_t out_result_reg;
    logic    out_vld_reg;
    logic    out_vld_next;
    logic    out_load;
    logic    in_take;

    cpm_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cpm_chan_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (out_load),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    assign out_load = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || out_load;
    assign in_take  = s_tvalid && s_tready;

    assign in_vld_next  = in_take || (in_vld_reg && !out_load);
    assign out_vld_next = out_load || (out_vld_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.opcode        <= s_tuser[1:0];
            in_item_reg.channel       <= s_tuser[2];
            in_item_reg.capture_value <= s_tdata[15:0];
            in_item_reg.elapsed_ms    <= s_tdata[31:16];
        end
        if (out_load)
        begin
            out_result_reg <= core_result;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'b0, out_result_reg.period_us};
    assign m_tuser  = {out_result_reg.period_ready, out_result_reg.channel_status};

    `ASSERT_CLKD(a_in_hold, in_vld_reg && !out_load |=> in_vld_reg, "input stage lost an item")
    `ASSERT_CLKD(a_empty_ready, !in_vld_reg |-> s_tready, "empty input stage not ready")
    `ASSERT_CLKD(a_ready_known, out_vld_reg && out_result_reg.period_ready |-> out_result_reg.channel_status == ST_KNOWN, "period ready without known state")
    `ASSERT_CLKD(a_zero_period, out_vld_reg && !out_result_reg.period_ready |-> out_result_reg.period_us == '0, "period nonzero while not ready")
    `ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !in_vld_reg && !out_vld_reg, "stages not empty in reset")

endmodule

// ===== tb/capture_period_monitor_unit_test.sv =====
// ----------------------------------------------------------------------------
// capture_period_monitor_unit_test
// Self-checking bench for the two-channel capture period monitor. A local
// predictor of channel state, timeouts and periods produces one expected
// status per input transfer. Directed cases cover edges, wrap, timeout expiry,
// start/stop, register decode and disabled capture mode. Random traffic then
// runs under several register settings with bursty input and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module capture_period_monitor_unit_test;
    import cpm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 200;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;   // capture_value, elapsed_ms
    logic [2:0]           s_tuser;   // opcode, channel
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;   // period_us, zero fill
    logic [2:0]           m_tuser;   // channel_status, period_ready
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [VAL_W-1:0]     cfg_data;

    // predictor state
    logic             mode_q;
    logic [VAL_W-1:0] timeout_q;
    logic [ST_W-1:0]  chan_state [CHANNELS];
    logic [VAL_W-1:0] last_cap   [CHANNELS];
    logic [VAL_W-1:0] tmo_left   [CHANNELS];
    logic [VAL_W-1:0] period_ticks [CHANNELS];

    result_t          status_q [$];
    result_t          got_status;
    result_t          want_status;
    logic [VAL_W-1:0] next_cap [CHANNELS];

    int errors      = 0;
    int idle_cycles = 0;
    int burst_left  = 0;
    int rdy_left    = 0;
    int rdy_mode    = 0;

    capture_period_monitor_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic result_t apply_item(input item_t it);
        result_t     r;
        int          c;
        logic [31:0] us;
        c = int'(it.channel);
        case (it.opcode)
            OP_TICK:
            begin
                if (mode_q)
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        if (tmo_left[i] != '0)
                        begin
                            if (it.elapsed_ms < tmo_left[i])
                                tmo_left[i] = tmo_left[i] - it.elapsed_ms;
                            else
                            begin
                                chan_state[i] = ST_ERROR;
                                tmo_left[i]   = '0;
                            end
                        end
                    end
                end
            end
            OP_CAPTURE:
            begin
                if (mode_q)
                begin
                    if (chan_state[c] == ST_ERROR || chan_state[c] == ST_UNKNOWN)
                        chan_state[c] = ST_WAIT;
                    else
                    begin
                        period_ticks[c] = it.capture_value - last_cap[c];
                        chan_state[c]   = ST_KNOWN;
                    end
                    last_cap[c] = it.capture_value;
                    tmo_left[c] = timeout_q;
                end
            end
            OP_START:
            begin
                if (mode_q)
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        chan_state[i] = ST_UNKNOWN;
                        tmo_left[i]   = timeout_q;
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    chan_state[i] = ST_UNKNOWN;
                    tmo_left[i]   = '0;
                end
            end
        endcase
        r.channel_status = chan_state[c];
        if (chan_state[c] == ST_KNOWN)
        begin
            us             = ({16'd0, period_ticks[c]} * 32'd256) / 32'd100;
            r.period_us    = us[PERIOD_W-1:0];
            r.period_ready = 1'b1;
        end
        else
        begin
            r.period_us    = '0;
            r.period_ready = 1'b0;
        end
        return r;
    endfunction

    task automatic send_op(input logic [OP_W-1:0] op, input logic ch,
                           input logic [VAL_W-1:0] cap, input logic [VAL_W-1:0] el);
        item_t it;
        int    gap;
        it.opcode        = op;
        it.channel       = ch;
        it.capture_value = cap;
        it.elapsed_ms    = el;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {it.elapsed_ms, it.capture_value};
        s_tuser  <= {it.channel, it.opcode};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        status_q.push_back(apply_item(it));
    endtask

    // stop input and wait for every outstanding status
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_CAPTURE_MODE)
            mode_q = data[0];
        else if (idx == CFG_EDGE_TIMEOUT)
            timeout_q = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_capture_edges();
        send_op(OP_TICK,    1'b0, 16'h0000, 16'h0000);
        send_op(OP_TICK,    1'b1, 16'hFFFF, 16'hFFFF);
        send_op(OP_CAPTURE, 1'b0, 16'h0000, 16'h0000);
        send_op(OP_CAPTURE, 1'b0, 16'hFFFF, 16'h0000);
        send_op(OP_CAPTURE, 1'b0, 16'hFFFF, 16'hFFFF);
        send_op(OP_CAPTURE, 1'b0, 16'h0005, 16'h0000);
        send_op(OP_CAPTURE, 1'b1, 16'h1234, 16'h0000);
        send_op(OP_CAPTURE, 1'b1, 16'h1233, 16'h0000);
    endtask

    task automatic test_timeout_and_control();
        send_op(OP_TICK,    1'b1, 16'h0000, 16'd199);
        send_op(OP_TICK,    1'b0, 16'h0000, 16'd0);
        send_op(OP_TICK,    1'b0, 16'h0000, 16'd1);
        send_op(OP_CAPTURE, 1'b0, 16'h8000, 16'h0000);
        send_op(OP_CAPTURE, 1'b0, 16'h8100, 16'h0000);
        send_op(OP_START,   1'b1, 16'h0000, 16'h0000);
        send_op(OP_TICK,    1'b0, 16'h0000, 16'hFFFF);
        send_op(OP_STOP,    1'b0, 16'h0000, 16'h0000);
        send_op(OP_TICK,    1'b1, 16'h0000, 16'hFFFF);
        send_op(OP_CAPTURE, 1'b1, 16'hAAAA, 16'h5555);
    endtask

    task automatic test_registers();
        settle();
        // spare indexes must not alter either register
        write_reg(CFG_SPARE_2, 16'h0000);
        write_reg(CFG_SPARE_3, 16'h0001);
        send_op(OP_CAPTURE, 1'b0, 16'h0100, 16'h0000);
        send_op(OP_TICK,    1'b0, 16'h0000, 16'd150);
        send_op(OP_TICK,    1'b0, 16'h0000, 16'd50);
        settle();
        write_reg(CFG_EDGE_TIMEOUT, 16'd1);
        send_op(OP_CAPTURE, 1'b0, 16'h0200, 16'h0000);
        send_op(OP_TICK,    1'b0, 16'h0000, 16'd1);
        settle();
        write_reg(CFG_EDGE_TIMEOUT, 16'd0);
        send_op(OP_START,   1'b1, 16'h0000, 16'h0000);
        send_op(OP_TICK,    1'b1, 16'h0000, 16'hFFFF);
        settle();
        write_reg(CFG_EDGE_TIMEOUT, 16'hFFFF);
        send_op(OP_CAPTURE, 1'b1, 16'h0300, 16'h0000);
        send_op(OP_TICK,    1'b1, 16'h0000, 16'hFFFE);
        send_op(OP_TICK,    1'b1, 16'h0000, 16'd1);
    endtask

    task automatic test_mode_off();
        settle();
        write_reg(CFG_CAPTURE_MODE, 16'hFFFE);
        send_op(OP_CAPTURE, 1'b1, 16'h0400, 16'h0000);
        send_op(OP_START,   1'b1, 16'h0000, 16'h0000);
        send_op(OP_STOP,    1'b1, 16'h0000, 16'h0000);
        settle();
        write_reg(CFG_CAPTURE_MODE, 16'h0001);
        send_op(OP_CAPTURE, 1'b1, 16'h0500, 16'h0000);
    endtask

    task automatic test_random_traffic();
        logic [VAL_W-1:0] tmo_list [8];
        logic             mode_list [8];
        logic [OP_W-1:0]  op;
        logic             ch;
        logic [VAL_W-1:0] cap;
        logic [VAL_W-1:0] el;
        int               pick;
        int               span;
        int               count;
        tmo_list  = '{16'd200, 16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0};
        mode_list = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        tmo_list[1] = 16'($urandom_range(2, 20));
        tmo_list[4] = 16'($urandom_range(50, 500));
        tmo_list[5] = 16'($urandom());
        tmo_list[6] = 16'($urandom_range(1, 65535));
        tmo_list[7] = 16'($urandom_range(1000, 5000));
        for (int p = 0; p < 8; p++)
        begin
            settle();
            write_reg(CFG_CAPTURE_MODE, {15'd0, mode_list[p]});
            write_reg(CFG_EDGE_TIMEOUT, tmo_list[p]);
            count = mode_list[p] ? PHASE_ITEMS : PHASE_ITEMS / 4;
            for (int n = 0; n < count; n++)
            begin
                ch   = 1'($urandom_range(0, 1));
                pick = $urandom_range(0, 99);
                cap  = 16'($urandom());
                el   = 16'($urandom());
                if (pick < 55)
                begin
                    op = OP_CAPTURE;
                    if ($urandom_range(0, 9) < 8)
                        next_cap[ch] = next_cap[ch] + 16'($urandom_range(0, 4000));
                    else
                        next_cap[ch] = 16'($urandom());
                    cap = next_cap[ch];
                end
                else if (pick < 88)
                begin
                    op   = OP_TICK;
                    span = (timeout_q != '0) ? int'(timeout_q / 16'd3) : 1000;
                    pick = $urandom_range(0, 9);
                    if (pick < 7)
                        el = 16'($urandom_range(0, span));
                    else if (pick < 9)
                        el = 16'($urandom_range(0, 255));
                end
                else if (pick < 95)
                    op = OP_START;
                else
                    op = OP_STOP;
                send_op(op, ch, cap, el);
            end
        end
    endtask

    // output stall pattern
    always @(negedge clk)
    begin
        if (rdy_left == 0)
        begin
            rdy_mode = $urandom_range(0, 3);
            rdy_left = $urandom_range(8, 60);
        end
        rdy_left--;
        case (rdy_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ((rdy_left % 12) >= 9);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_status.channel_status = m_tuser[1:0];
            got_status.period_ready   = m_tuser[2];
            got_status.period_us      = m_tdata[PERIOD_W-1:0];
            if (status_q.size() == 0)
            begin
                $display("%0t unexpected transfer: expected none, actual status %0d us %0d",
                         $time, got_status.channel_status, got_status.period_us);
                errors++;
            end
            else
            begin
                want_status = status_q.pop_front();
                if (got_status.channel_status !== want_status.channel_status)
                begin
                    $display("%0t channel_status: expected %0d actual %0d", $time,
                             want_status.channel_status, got_status.channel_status);
                    errors++;
                end
                if (got_status.period_us !== want_status.period_us)
                begin
                    $display("%0t period_us: expected %0d actual %0d", $time,
                             want_status.period_us, got_status.period_us);
                    errors++;
                end
                if (got_status.period_ready !== want_status.period_ready)
                begin
                    $display("%0t period_ready: expected %0d actual %0d", $time,
                             want_status.period_ready, got_status.period_ready);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        mode_q    = 1'b1;
        timeout_q = TIMEOUT_RESET;
        for (int i = 0; i < CHANNELS; i++)
        begin
            chan_state[i]   = ST_UNKNOWN;
            last_cap[i]     = '0;
            tmo_left[i]     = '0;
            period_ticks[i] = '0;
            next_cap[i]     = 16'($urandom());
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_capture_edges();
        test_timeout_and_control();
        test_registers();
        test_mode_off();
        test_random_traffic();
        settle();

        if (errors == 0 && status_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/cpm_pkg.sv
src/cpm_cfg_regs.sv
src/cpm_chan_core.sv
src/capture_period_monitor_unit.sv
tb/capture_period_monitor_unit_test.sv
